// ===== design/mve_pkg.sv =====
package mve_pkg;

  localparam int QueueDepth = 2;
  localparam int CfgIdxW = 2;

  localparam logic [7:0]  StartMarker = 8'hFE;
  localparam logic [7:0]  SeqByte     = 8'h00;
  localparam logic [15:0] CrcInit     = 16'hFFFF;
  localparam logic [7:0]  IdReset     = 8'h01;

  localparam logic [CfgIdxW-1:0] CfgSysId  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgCompId = CfgIdxW'(1);

  typedef struct packed {
    logic       start_req;
    logic [7:0] msg_id;
    logic [7:0] pay_len;
    logic [7:0] msg_seed;
    logic       byte_valid;
    logic [7:0] payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] idx;
    logic [7:0]         data;
  } cfg_item_t;

  // one queued job: optional header, optional payload byte, optional checksum
  typedef struct packed {
    logic       hdr;
    logic [7:0] msg_id;
    logic [7:0] len;
    logic [7:0] seed;
    logic       pay;
    logic [7:0] pbyte;
    logic       crc;
  } cmd_t;

  typedef enum logic [3:0] {
    PH_HDR0,
    PH_HDR1,
    PH_HDR2,
    PH_HDR3,
    PH_HDR4,
    PH_HDR5,
    PH_DATA,
    PH_CRCLO,
    PH_CRCHI
  } phase_t;

  // X.25 / MCRF4XX byte update
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

endpackage

// ===== design/mve_stream_if.sv =====
interface mve_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/mavlink_v1_frame_encoder.sv =====
// Each start or payload byte item is written to the job queue; its bytes are then registered
// in the output register. The checksum follows a payload byte only when it closes the frame.
// One payload item per cycle while out_ready holds; a start item occupies the emitter for
// its header, payload and checksum bytes; a 2-entry job queue absorbs bursts.
// Reset (synchronous, rst_n low): no frame open, queue empty, sys_id = comp_id = 1.
module mavlink_v1_frame_encoder #(
  parameter int QUEUE_DEPTH = mve_pkg::QueueDepth
) (
  input logic           clk,
  input logic           rst_n,
  mve_stream_if.sink    in_if,
  mve_stream_if.source  out_if,
  mve_stream_if.sink    cfg_if
);
  import mve_pkg::*;

  logic [7:0] sys_id_r, comp_id_r;

  logic      q_full, q_empty, push, pop;
  cmd_t      push_cmd, head_cmd;
  in_item_t  in_item;
  out_item_t out_item;
  cfg_item_t cfg_item;

  assign in_item        = in_if.payload;
  assign cfg_item       = cfg_if.payload;
  assign cfg_if.ready   = 1'b1;
  assign out_if.payload = out_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sys_id_r  <= IdReset;
      comp_id_r <= IdReset;
    end else if (cfg_if.valid) begin
      if (cfg_item.idx == CfgSysId) begin
        sys_id_r <= cfg_item.data;
      end else if (cfg_item.idx == CfgCompId) begin
        comp_id_r <= cfg_item.data;
      end
    end
  end

  mve_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_item  (in_item),
    .in_ready (in_if.ready),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  mve_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (head_cmd),
    .empty     (q_empty)
  );

  mve_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head_cmd),
    .q_empty   (q_empty),
    .pop       (pop),
    .sys_id    (sys_id_r),
    .comp_id   (comp_id_r),
    .out_valid (out_if.valid),
    .out_item  (out_item),
    .out_ready (out_if.ready)
  );

endmodule

// ===== design/mve_front.sv =====
module mve_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  mve_pkg::in_item_t in_item,
  output logic              in_ready,
  input  logic              q_full,
  output logic              push,
  output mve_pkg::cmd_t     cmd
);
  import mve_pkg::*;

  logic       open_r, open_nxt;
  logic [7:0] frame_length_r, frame_length_nxt;
  logic [7:0] bytes_sent_r, bytes_sent_nxt;
  logic [7:0] seed_r, seed_nxt;

  logic       acc;
  logic       zero_len;
  logic       open_mid;
  logic [7:0] sent_mid;
  logic [7:0] sent_inc;
  logic       take;
  logic       close;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    zero_len         = (in_item.pay_len == 8'h00);
    open_mid         = in_item.start_req ? !zero_len : open_r;
    frame_length_nxt = in_item.start_req ? in_item.pay_len : frame_length_r;
    sent_mid         = in_item.start_req ? 8'h00 : bytes_sent_r;
    seed_nxt         = in_item.start_req ? in_item.msg_seed : seed_r;
    take             = in_item.byte_valid && open_mid;
    sent_inc         = sent_mid + 8'h01;
    close            = take && (sent_inc == frame_length_nxt);
    open_nxt         = open_mid && !close;
    bytes_sent_nxt   = take ? sent_inc : sent_mid;

    cmd.hdr    = in_item.start_req;
    cmd.msg_id = in_item.msg_id;
    cmd.len    = in_item.pay_len;
    cmd.seed   = seed_nxt;
    cmd.pay    = take;
    cmd.pbyte  = in_item.payload_byte;
    cmd.crc    = (in_item.start_req && zero_len) || close;

    push = acc && (in_item.start_req || take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r         <= 1'b0;
      frame_length_r <= 8'h00;
      bytes_sent_r   <= 8'h00;
      seed_r         <= 8'h00;
    end else if (acc) begin
      open_r         <= open_nxt;
      frame_length_r <= frame_length_nxt;
      bytes_sent_r   <= bytes_sent_nxt;
      seed_r         <= seed_nxt;
    end
  end

  a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> (bytes_sent_r < frame_length_r))
    else $error("payload count reached length with frame still open");

endmodule

// ===== design/mve_queue.sv =====
module mve_queue #(
  parameter int DEPTH = mve_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mve_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output mve_pkg::cmd_t pop_data,
  output logic          empty
);
  import mve_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  cmd_t            mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;

  assign full     = (count_r == CntW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && full) |-> pop)
    else $error("queue write while full");

endmodule

// ===== design/mve_back.sv =====
module mve_back (
  input  logic               clk,
  input  logic               rst_n,
  input  mve_pkg::cmd_t      head,
  input  logic               q_empty,
  output logic               pop,
  input  logic [7:0]         sys_id,
  input  logic [7:0]         comp_id,
  output logic               out_valid,
  output mve_pkg::out_item_t out_item,
  input  logic               out_ready
);
  import mve_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic        mid_r;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r;
  out_item_t   out_item_r;

  phase_t      ph;
  logic        have_nxt;
  logic        adv;
  logic [7:0]  byte_sel;
  logic [7:0]  fold_in;
  logic [15:0] folded;
  logic        end_sel;

  assign adv       = !q_empty && (!out_valid_r || out_ready);
  assign pop       = adv && !have_nxt;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    if (mid_r) begin
      ph = phase_r;
    end else if (head.hdr) begin
      ph = PH_HDR0;
    end else if (head.pay) begin
      ph = PH_DATA;
    end else begin
      ph = PH_CRCLO;
    end
  end

  // next phase
  always_comb begin
    phase_nxt = PH_HDR0;
    have_nxt  = 1'b0;
    case (ph)
      PH_HDR0: begin
        phase_nxt = PH_HDR1;
        have_nxt  = 1'b1;
      end
      PH_HDR1: begin
        phase_nxt = PH_HDR2;
        have_nxt  = 1'b1;
      end
      PH_HDR2: begin
        phase_nxt = PH_HDR3;
        have_nxt  = 1'b1;
      end
      PH_HDR3: begin
        phase_nxt = PH_HDR4;
        have_nxt  = 1'b1;
      end
      PH_HDR4: begin
        phase_nxt = PH_HDR5;
        have_nxt  = 1'b1;
      end
      PH_HDR5: begin
        phase_nxt = head.pay ? PH_DATA : PH_CRCLO;
        have_nxt  = head.pay || head.crc;
      end
      PH_DATA: begin
        phase_nxt = PH_CRCLO;
        have_nxt  = head.crc;
      end
      PH_CRCLO: begin
        phase_nxt = PH_CRCHI;
        have_nxt  = 1'b1;
      end
      default: begin
        phase_nxt = PH_HDR0;
        have_nxt  = 1'b0;
      end
    endcase
  end

  // byte and checksum for the current phase
  always_comb begin
    byte_sel = SeqByte;
    fold_in  = SeqByte;
    end_sel  = 1'b0;
    case (ph)
      PH_HDR0:  byte_sel = StartMarker;
      PH_HDR1:  byte_sel = head.len;
      PH_HDR2:  byte_sel = SeqByte;
      PH_HDR3:  byte_sel = sys_id;
      PH_HDR4:  byte_sel = comp_id;
      PH_HDR5:  byte_sel = head.msg_id;
      PH_DATA:  byte_sel = head.pbyte;
      PH_CRCLO: byte_sel = 8'h00;
      PH_CRCHI: begin
        byte_sel = crc_r[15:8];
        end_sel  = 1'b1;
      end
      default:  byte_sel = SeqByte;
    endcase
    fold_in = (ph == PH_CRCLO) ? head.seed : byte_sel;
    folded  = crc_fold(crc_r, fold_in);
    case (ph)
      PH_HDR0:  crc_nxt = CrcInit;
      PH_CRCHI: crc_nxt = crc_r;
      default:  crc_nxt = folded;
    endcase
    if (ph == PH_CRCLO) begin
      byte_sel = folded[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r.out_byte  <= byte_sel;
      out_item_r.frame_end <= end_sel;
      out_item_r.last      <= !have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR0;
      mid_r       <= 1'b0;
      crc_r       <= CrcInit;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_r <= 1'b1;
        crc_r       <= crc_nxt;
        mid_r       <= have_nxt;
        phase_r     <= phase_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.frame_end) |-> out_item_r.last)
    else $error("frame end byte not flagged last");

  a_crc_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && ph == PH_CRCLO) |=> (mid_r && phase_r == PH_CRCHI))
    else $error("checksum low byte not followed by high byte");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule
